// File: rtl/core/sfm_pkg.sv
`default_nettype none

package sfm_pkg;

    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int NEEDLE_BYTES      = 16;
    localparam int NEEDLE_BITS       = 8 * NEEDLE_BYTES;
    localparam int LENGTH_BITS       = 5;
    localparam int START_BITS        = 16;
    localparam int CFG_DATA_BITS     = 64;

    typedef enum logic [1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_LENGTH       = 2'd2,
        CFG_SEARCH_START = 2'd3
    } cfg_reg_t;

    function automatic logic [7:0] needle_byte(input logic [NEEDLE_BITS-1:0] needle,
                                               input logic [LENGTH_BITS-1:0] idx);
        logic [7:0] result;
        if (idx < LENGTH_BITS'(NEEDLE_BYTES)) begin
            result = needle[{idx[3:0], 3'b000} +: 8];
        end else begin
            result = 8'd0;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sfm_cell.sv
`default_nettype none

module sfm_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              shift_en,
    input  wire logic                              clear_en,
    input  wire logic [7:0]                        din,
    input  wire logic [sfm_pkg::LENGTH_BITS-1:0]   pattern_length,
    input  wire logic [sfm_pkg::NEEDLE_BITS-1:0]   needle,
    output logic      [7:0]                        dout,
    output logic                                   cell_ok
);
    import sfm_pkg::*;

    localparam logic [6:0] IDX_W = 7'(INDEX);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       active;
    logic [6:0] needle_idx_full;
    logic [7:0] needle_sel;

    // The cell at window slot k checks the byte entering it against needle
    // byte (length - 1 - k), so the whole window lines up with the needle.
    assign active          = {2'b00, pattern_length} > IDX_W;
    assign needle_idx_full = {2'b00, pattern_length} - 7'd1 - IDX_W;
    assign needle_sel      = needle_byte(needle, needle_idx_full[LENGTH_BITS-1:0]);
    assign cell_ok         = !active || (din == needle_sel);

    always_comb begin
        byte_next = byte_reg;
        if (clear_en) begin
            byte_next = 8'd0;
        end else if (shift_en) begin
            byte_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

`default_nettype wire

// File: rtl/core/substring_first_match.sv
`default_nettype none

// Exact substring search over a byte stream.
// Configuration: write the needle bytes, the needle length and the start
// position over the cfg channel while the block is idle. A cfg beat is taken
// in every cycle.
// Input: one text byte per s_ beat, s_tlast on the last byte of a text. Each
// byte shifts into a row of MAX_PATTERN cells that compare the window with
// the needle in the cycle the byte is accepted, so a byte is taken in every
// cycle unless the output stalls, and the rate is one byte per cycle.
// Output: one m_ beat per text, registered, in the cycle after the last byte is
// accepted. m_tuser is the found flag and m_tdata the first match position.
// If the receiver stalls, the result waits in the output register; the input
// keeps moving as long as the register is empty or being drained in the
// same cycle.
// After the last byte the window, the byte count and the hit are cleared.
// Reset clears all registers and the configuration to zero.

module substring_first_match #(
    parameter int MAX_PATTERN   = sfm_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = sfm_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [sfm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // text_byte
    input  wire logic                                s_tlast,   // final_byte
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // match_position
    output logic                                     m_tuser    // match_found
);
    import sfm_pkg::*;

    localparam int CW = POSITION_BITS + 1;
    localparam int SW = ((CW > START_BITS + 1) ? CW : START_BITS + 1) + 1;

    logic [63:0]              pattern_low_reg;
    logic [63:0]              pattern_high_reg;
    logic [LENGTH_BITS-1:0]   pattern_length_reg;
    logic [START_BITS-1:0]    search_start_reg;

    logic [CW-1:0]            count_reg;
    logic                     hit_reg;
    logic [15:0]              hit_index_reg;
    logic [CW-1:0]            count_next;
    logic                     hit_next;
    logic [15:0]              hit_index_next;

    logic                     m_valid_reg;
    logic                     m_found_reg;
    logic [15:0]              m_position_reg;
    logic                     m_valid_next;
    logic                     m_found_next;
    logic [15:0]              m_position_next;

    logic                     accept;
    logic                     room;
    logic [CW-1:0]            count_step;
    logic [CW-1:0]            count_after;
    logic                     shift_en;
    logic                     clear_en;
    logic                     length_ok;
    logic                     reach;
    logic                     all_ok;
    logic                     new_hit;
    logic                     hit_after;
    logic [SW-1:0]            index_full;
    logic [15:0]              index_after;
    logic                     empty_ok;
    logic                     res_found;
    logic [15:0]              res_position;

    logic [NEEDLE_BITS-1:0]   needle;
    logic [7:0]               window [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]   cell_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            search_start_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                CFG_LENGTH:       pattern_length_reg <= cfg_data[LENGTH_BITS-1:0];
                CFG_SEARCH_START: search_start_reg   <= cfg_data[START_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign needle   = {pattern_high_reg, pattern_low_reg};
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Bytes past the position range are neither counted nor shifted in.
    assign room        = !count_reg[CW-1];
    assign count_step  = count_reg + CW'(1);
    assign count_after = room ? count_step : count_reg;
    assign shift_en    = accept && room;
    assign clear_en    = accept && s_tlast;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            logic [7:0] cell_in;
            if (k == 0) begin : g_head
                assign cell_in = s_tdata;
            end else begin : g_link
                assign cell_in = window[k-1];
            end
            sfm_cell #(
                .INDEX (k)
            ) u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .shift_en       (shift_en),
                .clear_en       (clear_en),
                .din            (cell_in),
                .pattern_length (pattern_length_reg),
                .needle         (needle),
                .dout           (window[k]),
                .cell_ok        (cell_ok[k])
            );
        end
    endgenerate

    assign all_ok    = &cell_ok;
    assign length_ok = (pattern_length_reg != '0) &&
                       ({2'b00, pattern_length_reg} <= 7'(MAX_PATTERN));
    assign reach     = SW'(count_step) >= (SW'(pattern_length_reg) + SW'(search_start_reg));
    assign new_hit   = room && !hit_reg && length_ok && reach && all_ok;
    assign index_full  = SW'(count_step) - SW'(pattern_length_reg);
    assign hit_after   = hit_reg || new_hit;
    assign index_after = new_hit ? index_full[15:0] : hit_index_reg;

    assign empty_ok = SW'(search_start_reg) <= SW'(count_after);

    always_comb begin
        if (pattern_length_reg == '0) begin
            res_found    = empty_ok;
            res_position = empty_ok ? search_start_reg : 16'd0;
        end else begin
            res_found    = hit_after;
            res_position = hit_after ? index_after : 16'd0;
        end
    end

    always_comb begin
        count_next     = count_reg;
        hit_next       = hit_reg;
        hit_index_next = hit_index_reg;
        if (accept) begin
            if (s_tlast) begin
                count_next     = '0;
                hit_next       = 1'b0;
                hit_index_next = 16'd0;
            end else begin
                count_next     = count_after;
                hit_next       = hit_after;
                hit_index_next = index_after;
            end
        end
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_found_next    = m_found_reg;
        m_position_next = m_position_reg;
        if (accept && s_tlast) begin
            m_valid_next    = 1'b1;
            m_found_next    = res_found;
            m_position_next = res_position;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            hit_index_reg <= 16'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            hit_index_reg <= hit_index_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_found_reg    <= 1'b0;
            m_position_reg <= 16'd0;
        end else begin
            m_found_reg    <= m_found_next;
            m_position_reg <= m_position_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_position_reg;

endmodule

`default_nettype wire
